/* hw/rtl/bnl_pkg.sv */
// ----------------------------------------------------------------------------
// bnl_pkg
// shared types and constants for the batch normalization block
// ----------------------------------------------------------------------------
`default_nettype none

package bnl_pkg;

    localparam int MAX_ROWS     = 32;
    localparam int MAX_FEATURES = 64;
    localparam int DATA_W       = 16;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int FEAT_W   = $clog2(MAX_FEATURES);
    localparam int ADDR_W   = ROW_W + FEAT_W;
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int FCNT_W   = $clog2(MAX_FEATURES + 1);
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 3;
    localparam int VAR_W    = 32;
    localparam int INV_W    = 24;
    localparam int MOM_W    = 16;

    localparam int SUM_W    = DATA_W + ROW_W + 1;
    localparam int SQ_W     = 2 * (DATA_W + 1) + ROW_W;
    localparam int DVD_W    = 49;
    localparam int DVS_W    = VAR_W + 1;
    localparam int SQRT_N   = (DVD_W + 1) / 2;

    localparam logic [DATA_W-1:0] GAMMA_ONE = DATA_W'(256);
    localparam logic [INV_W-1:0]  INV_MAX   = {INV_W{1'b1}};
    localparam logic [VAR_W-1:0]  VAR_MAX   = {VAR_W{1'b1}};

    typedef enum logic [1:0] {
        FN_PARAM  = 2'd0,
        FN_SAMPLE = 2'd1,
        FN_STATS  = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TRAIN = 3'd0,
        CFG_ROWS  = 3'd1,
        CFG_FEATS = 3'd2,
        CFG_MOM   = 3'd3,
        CFG_EPS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_RD1    = 16'h0002,
        ST_RD2    = 16'h0004,
        ST_RDOUT  = 16'h0008,
        ST_FEAT   = 16'h0010,
        ST_INF    = 16'h0020,
        ST_SUM    = 16'h0040,
        ST_MDIV   = 16'h0080,
        ST_SQ     = 16'h0100,
        ST_VDIV   = 16'h0200,
        ST_BLEND1 = 16'h0400,
        ST_BLEND2 = 16'h0800,
        ST_INV    = 16'h1000,
        ST_RDIV   = 16'h2000,
        ST_ROOT   = 16'h4000,
        ST_WRITE  = 16'h8000
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/batch_norm_layer.sv */
// ----------------------------------------------------------------------------
// batch_norm_layer
// fixed point batch normalization forward pass with running statistics
// ----------------------------------------------------------------------------
// One transaction at a time. An output read runs through a memory read, two
// multiplies and a round and saturate step, and leaves its result in an output
// register, so the next transaction is taken while that result waits. The
// statistics step walks the features one after another through the sample
// memory and a shared one-bit-per-cycle divider and square root unit.
// Gamma, beta and running statistics come out of reset through per-feature
// valid bits, so there is no clearing pass after reset.
`default_nettype none

module batch_norm_layer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_func,
    input  wire  [4:0]                   i_row,
    input  wire  [5:0]                   i_feature,
    input  wire  signed [15:0]           i_value,
    input  wire  signed [15:0]           i_shift_value,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [15:0]           o_normalized,
    output logic [4:0]                   o_out_row,
    output logic [5:0]                   o_out_feature,
    output logic                         o_status,
    input  wire                          i_cfg_we,
    input  wire  [bnl_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  wire  [bnl_pkg::CFG_W-1:0]    i_cfg_data
);
    import bnl_pkg::*;

    // configuration
    logic              r_train;
    logic [5:0]        r_batch_rows;
    logic [6:0]        r_feat_count;
    logic [MOM_W-1:0]  r_mom;
    logic [15:0]       r_eps;

    // memories
    logic [DATA_W-1:0]         r_samp_mem [2**ADDR_W];
    logic [2*DATA_W-1:0]       r_gb_mem   [MAX_FEATURES];
    logic [DATA_W+VAR_W-1:0]   r_run_mem  [MAX_FEATURES];
    logic [DATA_W+INV_W-1:0]   r_norm_mem [MAX_FEATURES];
    logic [DATA_W-1:0]         r_samp_q;
    logic [2*DATA_W-1:0]       r_gb_q;
    logic [DATA_W+VAR_W-1:0]   r_run_q;
    logic [DATA_W+INV_W-1:0]   r_norm_q;
    logic [MAX_FEATURES-1:0]   r_gb_vld;
    logic [MAX_FEATURES-1:0]   r_run_vld;
    logic                      r_gb_hit;
    logic                      r_run_hit;

    // control
    t_state            r_state;
    logic              r_stats_ready;
    logic [RCNT_W-1:0] r_lat_rows;
    logic [FCNT_W-1:0] r_lat_feats;
    logic [RCNT_W-1:0] r_rows;
    logic [FCNT_W-1:0] r_feats;
    logic [RCNT_W-1:0] r_i;
    logic [FCNT_W-1:0] r_j;
    logic              r_iss;
    logic              r_sqv;
    logic [5:0]        r_cnt;

    // datapath
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_neg;
    logic [SQ_W-1:0]           r_sq;
    logic [2*DATA_W+1:0]       r_sqp;
    logic signed [DATA_W-1:0]  r_mean;
    logic [VAR_W-1:0]          r_var;
    logic [INV_W-1:0]          r_inv;
    logic signed [32:0]        r_pa;
    logic signed [33:0]        r_pb;
    logic [47:0]               r_pc;
    logic [48:0]               r_pd;
    logic [DVD_W-1:0]          r_quo;
    logic [DVS_W-1:0]          r_rem;
    logic [DVS_W-1:0]          r_dvs;
    logic [DVD_W-1:0]          r_t;
    logic [DVD_W:0]            r_res;
    logic [DVD_W-1:0]          r_bit;

    // read transaction
    logic [ROW_W-1:0]          r_rd_row;
    logic [FEAT_W-1:0]         r_rd_feat;
    logic                      r_bad;
    logic signed [32:0]        r_dg;
    logic signed [DATA_W-1:0]  r_beta;
    logic signed [57:0]        r_p;

    logic in_acc;
    t_func func;
    logic [RCNT_W-1:0] eff_rows;
    logic [FCNT_W-1:0] eff_feats;
    logic out_free;

    assign func       = t_func'(i_func);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !(o_out_valid && i_out_stall);

    always_comb begin
        if (r_batch_rows == '0) begin
            eff_rows = RCNT_W'(1);
        end else if (32'(r_batch_rows) > MAX_ROWS) begin
            eff_rows = RCNT_W'(MAX_ROWS);
        end else begin
            eff_rows = RCNT_W'(r_batch_rows);
        end
        if (r_feat_count == '0) begin
            eff_feats = FCNT_W'(1);
        end else if (32'(r_feat_count) > MAX_FEATURES) begin
            eff_feats = FCNT_W'(MAX_FEATURES);
        end else begin
            eff_feats = FCNT_W'(r_feat_count);
        end
    end

    // memory port control
    logic                samp_we, samp_re;
    logic [ADDR_W-1:0]   samp_waddr, samp_raddr;
    logic                gb_we, rd_re, run_re, run_we, norm_we;
    logic [DATA_W+VAR_W-1:0] run_wdata;

    assign samp_we    = in_acc && (func == FN_SAMPLE);
    assign samp_waddr = {i_row, i_feature};
    assign gb_we      = in_acc && (func == FN_PARAM);
    assign rd_re      = in_acc && (func == FN_READ);
    assign run_re     = (r_state == ST_FEAT);
    assign run_we     = (r_state == ST_BLEND2);
    assign norm_we    = (r_state == ST_WRITE);

    always_comb begin
        samp_re    = rd_re;
        samp_raddr = {i_row, i_feature};
        if ((r_state == ST_SUM || r_state == ST_SQ) && r_i < r_rows) begin
            samp_re    = 1'b1;
            samp_raddr = {r_i[ROW_W-1:0], r_j[FEAT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (samp_we) begin
            r_samp_mem[samp_waddr] <= i_value;
        end
        if (samp_re) begin
            r_samp_q <= r_samp_mem[samp_raddr];
        end
        if (gb_we) begin
            r_gb_mem[i_feature] <= {i_value, i_shift_value};
        end
        if (rd_re) begin
            r_gb_q   <= r_gb_mem[i_feature];
            r_norm_q <= r_norm_mem[i_feature];
        end
        if (run_we) begin
            r_run_mem[r_j[FEAT_W-1:0]] <= run_wdata;
        end
        if (run_re) begin
            r_run_q <= r_run_mem[r_j[FEAT_W-1:0]];
        end
        if (norm_we) begin
            r_norm_mem[r_j[FEAT_W-1:0]] <= {r_mean, r_inv};
        end
    end

    // shared divider step
    logic [DVS_W:0]   div_sh;
    logic             div_ge;
    logic [DVS_W-1:0] div_rem_n;
    always_comb begin
        div_sh    = {r_rem, r_quo[DVD_W-1]};
        div_ge    = (div_sh >= {1'b0, r_dvs});
        div_rem_n = div_ge ? DVS_W'(div_sh - {1'b0, r_dvs}) : div_sh[DVS_W-1:0];
    end

    // square root step
    logic [DVD_W:0] sq_trial;
    logic           sq_ge;
    assign sq_trial = r_res + {1'b0, r_bit};
    assign sq_ge    = ({1'b0, r_t} >= sq_trial);

    // arithmetic helpers
    logic signed [DATA_W:0]   pass_d;
    logic signed [DATA_W:0]   mean_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [DATA_W-1:0] rmean_eff;
    logic [VAR_W-1:0]         rvar_eff;
    logic [MOM_W:0]           om;
    logic signed [34:0]       rm_sum;
    logic [49:0]              rv_sum;
    logic [DVS_W-1:0]         v_eps;
    logic signed [DATA_W:0]   rd_d;
    logic signed [DATA_W-1:0] rd_gamma;
    logic signed [33:0]       rd_sh;
    logic signed [34:0]       rd_res;
    logic signed [DATA_W-1:0] rd_sat;

    always_comb begin
        pass_d    = $signed({r_samp_q[DATA_W-1], r_samp_q}) - (DATA_W+1)'(r_mean);
        sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        mean_mag  = $signed({1'b0, r_quo[DATA_W-1:0]}) + (DATA_W+1)'(r_rem != '0);
        rmean_eff = r_run_hit ? $signed(r_run_q[DATA_W+VAR_W-1:VAR_W]) : '0;
        rvar_eff  = r_run_hit ? r_run_q[VAR_W-1:0] : '0;
        om        = (MOM_W+1)'(1 << MOM_W) - (MOM_W+1)'(r_mom);
        rm_sum    = 35'(r_pa) + 35'(r_pb) + 35'sd32768;
        rv_sum    = 50'(r_pc) + 50'(r_pd) + 50'd32768;
        run_wdata = {rm_sum[31:16],
                     (rv_sum[49:48] != '0) ? VAR_MAX : rv_sum[47:16]};
        v_eps     = {1'b0, r_var} + DVS_W'(r_eps);
        rd_d      = $signed({r_samp_q[DATA_W-1], r_samp_q}) -
                    (DATA_W+1)'($signed(r_norm_q[DATA_W+INV_W-1:INV_W]));
        rd_gamma  = r_gb_hit ? $signed(r_gb_q[2*DATA_W-1:DATA_W]) : GAMMA_ONE;
        rd_sh     = 34'((r_p + 58'sd8388608) >>> 24);
        rd_res    = 35'(rd_sh) + 35'(r_beta);
        if (rd_res > 35'sd32767) begin
            rd_sat = 16'sh7fff;
        end else if (rd_res < -35'sd32768) begin
            rd_sat = -16'sh8000;
        end else begin
            rd_sat = rd_res[DATA_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train      <= 1'b0;
            r_batch_rows <= 6'd32;
            r_feat_count <= 7'd64;
            r_mom        <= 16'd64881;
            r_eps        <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRAIN: r_train      <= i_cfg_data[0];
                CFG_ROWS:  r_batch_rows <= i_cfg_data[5:0];
                CFG_FEATS: r_feat_count <= i_cfg_data[6:0];
                CFG_MOM:   r_mom        <= i_cfg_data;
                CFG_EPS:   r_eps        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (r_state == ST_RDOUT && out_free) begin
                o_out_valid <= 1'b1;
            end
        end
        if (r_state == ST_RDOUT && out_free) begin
            o_normalized  <= r_bad ? '0 : rd_sat;
            o_out_row     <= r_rd_row;
            o_out_feature <= r_rd_feat;
            o_status      <= r_bad;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_stats_ready <= 1'b0;
            r_lat_rows    <= '0;
            r_lat_feats   <= '0;
            r_gb_vld      <= '0;
            r_run_vld     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (func)
                            FN_PARAM: begin
                                r_gb_vld[i_feature] <= 1'b1;
                            end
                            FN_SAMPLE: ;
                            FN_STATS: begin
                                r_rows  <= eff_rows;
                                r_feats <= eff_feats;
                                r_j     <= '0;
                                r_state <= ST_FEAT;
                            end
                            FN_READ: begin
                                r_rd_row  <= i_row;
                                r_rd_feat <= i_feature;
                                r_gb_hit  <= r_gb_vld[i_feature];
                                r_bad     <= !(r_stats_ready &&
                                               RCNT_W'(i_row) < r_lat_rows &&
                                               FCNT_W'(i_feature) < r_lat_feats);
                                r_state   <= ST_RD1;
                            end
                        endcase
                    end
                end
                ST_RD1: begin
                    r_dg    <= rd_d * rd_gamma;
                    r_beta  <= r_gb_hit ? $signed(r_gb_q[DATA_W-1:0]) : '0;
                    r_inv   <= r_norm_q[INV_W-1:0];
                    r_state <= ST_RD2;
                end
                ST_RD2: begin
                    r_p     <= r_dg * $signed({1'b0, r_inv});
                    r_state <= ST_RDOUT;
                end
                ST_RDOUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FEAT: begin
                    r_run_hit <= r_run_vld[r_j[FEAT_W-1:0]];
                    r_i       <= '0;
                    r_iss     <= 1'b0;
                    r_sum     <= '0;
                    r_state   <= r_train ? ST_SUM : ST_INF;
                end
                ST_INF: begin
                    r_mean  <= rmean_eff;
                    r_var   <= rvar_eff;
                    r_state <= ST_INV;
                end
                ST_SUM: begin
                    r_iss <= (r_i < r_rows);
                    if (r_i < r_rows) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (r_iss) begin
                        r_sum <= r_sum + SUM_W'($signed(r_samp_q));
                    end
                    if (r_i == r_rows && !r_iss) begin
                        r_neg   <= r_sum[SUM_W-1];
                        r_quo   <= DVD_W'(sum_mag);
                        r_rem   <= '0;
                        r_dvs   <= DVS_W'(r_rows);
                        r_cnt   <= 6'(DVD_W);
                        r_state <= ST_MDIV;
                    end
                end
                ST_MDIV: begin
                    if (r_cnt != '0) begin
                        r_quo <= {r_quo[DVD_W-2:0], div_ge};
                        r_rem <= div_rem_n;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        // floor: a negative sum with a remainder rounds away from zero
                        r_mean  <= r_neg ? DATA_W'(-mean_mag) : r_quo[DATA_W-1:0];
                        r_i     <= '0;
                        r_iss   <= 1'b0;
                        r_sqv   <= 1'b0;
                        r_sq    <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_iss <= (r_i < r_rows);
                    if (r_i < r_rows) begin
                        r_i <= r_i + 1'b1;
                    end
                    r_sqv <= r_iss;
                    if (r_iss) begin
                        r_sqp <= (2*DATA_W+2)'(pass_d * pass_d);
                    end
                    if (r_sqv) begin
                        r_sq <= r_sq + SQ_W'(r_sqp);
                    end
                    if (r_i == r_rows && !r_iss && !r_sqv) begin
                        r_quo   <= DVD_W'(r_sq);
                        r_rem   <= '0;
                        r_dvs   <= DVS_W'(r_rows);
                        r_cnt   <= 6'(DVD_W);
                        r_state <= ST_VDIV;
                    end
                end
                ST_VDIV: begin
                    if (r_cnt != '0) begin
                        r_quo <= {r_quo[DVD_W-2:0], div_ge};
                        r_rem <= div_rem_n;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_var   <= (r_quo[DVD_W-1:VAR_W] != '0) ? VAR_MAX
                                                                 : r_quo[VAR_W-1:0];
                        r_state <= ST_BLEND1;
                    end
                end
                ST_BLEND1: begin
                    r_pa    <= rmean_eff * $signed({1'b0, r_mom});
                    r_pb    <= r_mean * $signed({1'b0, om});
                    r_pc    <= rvar_eff * r_mom;
                    r_pd    <= r_var * om;
                    r_state <= ST_BLEND2;
                end
                ST_BLEND2: begin
                    r_run_vld[r_j[FEAT_W-1:0]] <= 1'b1;
                    r_state <= ST_INV;
                end
                ST_INV: begin
                    if (v_eps == '0) begin
                        r_inv   <= INV_MAX;
                        r_state <= ST_WRITE;
                    end else begin
                        r_quo   <= DVD_W'(1) << 48;
                        r_rem   <= '0;
                        r_dvs   <= v_eps;
                        r_cnt   <= 6'(DVD_W);
                        r_state <= ST_RDIV;
                    end
                end
                ST_RDIV: begin
                    if (r_cnt != '0) begin
                        r_quo <= {r_quo[DVD_W-2:0], div_ge};
                        r_rem <= div_rem_n;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_t     <= r_quo;
                        r_res   <= '0;
                        r_bit   <= DVD_W'(1) << 48;
                        r_cnt   <= 6'(SQRT_N);
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (r_cnt != '0) begin
                        if (sq_ge) begin
                            r_t   <= DVD_W'({1'b0, r_t} - sq_trial);
                            r_res <= (r_res >> 1) + {1'b0, r_bit};
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_inv   <= (r_res[DVD_W:INV_W] != '0) ? INV_MAX
                                                               : r_res[INV_W-1:0];
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (r_j + 1'b1 == r_feats) begin
                        r_lat_rows    <= r_rows;
                        r_lat_feats   <= r_feats;
                        r_stats_ready <= 1'b1;
                        r_state       <= ST_IDLE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_FEAT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_status_needs_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |-> r_stats_ready)
        else $error("valid status without statistics");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MDIV || r_state == ST_VDIV || r_state == ST_RDIV)
        |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && r_cnt == '0) |-> (r_res <= ((DVD_W+1)'(1) << INV_W)))
        else $error("square root result out of range");

    a_latch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stats_ready) |-> (r_lat_rows != '0 && r_lat_feats != '0))
        else $error("statistics latched with empty counts");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// regression bench for batch_norm_layer: directed corner cases, then random
// phases of parameter/sample loads, statistics steps and output reads, checked
// transaction by transaction against a behavioral predictor of the layer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bnl_pkg::*;

    localparam int LIMIT = 4000000;

    typedef struct {
        logic signed [15:0] norm;
        logic [4:0]         row;
        logic [5:0]         feat;
        logic               status;
    } t_bn_result;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            func;
    logic [4:0]            row;
    logic [5:0]            feat;
    logic signed [15:0]    value;
    logic signed [15:0]    shift_value;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    normalized;
    logic [4:0]            out_row;
    logic [5:0]            out_feat;
    logic                  status;
    logic                  cfg_we;
    logic [CIDX_W-1:0]     cfg_idx;
    logic [CFG_W-1:0]      cfg_data;

    // predictor state
    logic signed [15:0] samples [MAX_ROWS][MAX_FEATURES];
    bit                 loaded [MAX_ROWS][MAX_FEATURES];
    int                 gamma_m [MAX_FEATURES];
    int                 beta_m [MAX_FEATURES];
    int                 avg_m [MAX_FEATURES];
    longint             run_var [MAX_FEATURES];
    int                 mean_used [MAX_FEATURES];
    longint             inv_std [MAX_FEATURES];
    bit                 stats_ok;
    int                 lat_rows;
    int                 lat_feats;
    bit                 train_r;
    int                 rows_r;
    int                 feats_r;
    longint             mom_r;
    longint             eps_r;

    t_bn_result expected_norm_q [$];
    bit         stats_pending;
    bit         in_idle;
    bit         out_idle;
    int         hold;
    int         errors;
    int         n_items;
    int         n_results;
    int         n_stats;
    longint     cycles;

    batch_norm_layer u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (func),
        .i_row         (row),
        .i_feature     (feat),
        .i_value       (value),
        .i_shift_value (shift_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_normalized  (normalized),
        .o_out_row     (out_row),
        .o_out_feature (out_feat),
        .o_status      (status),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("batch_norm_layer regression: fail");
            $finish;
        end
    end

    function automatic int eff_count(int c, int max);
        if (c == 0) return 1;
        return (c > max) ? max : c;
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint int_sqrt(longint t);
        longint unsigned res;
        longint unsigned cand;
        res = 0;
        for (int b = 26; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= t) res = cand;
        end
        return longint'(res);
    endfunction

    function automatic longint inv_root(longint var_q);
        longint v;
        longint q;
        v = var_q + eps_r;
        if (v == 0) return 64'hFFFFFF;
        q = int_sqrt((64'd1 << 48) / v);
        return (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
    endfunction

    task automatic bn_stats();
        int     nr;
        int     nf;
        longint sum;
        longint sq;
        longint d;
        longint mean;
        longint var_q;
        longint rm;
        longint rv;
        nr = eff_count(rows_r, MAX_ROWS);
        nf = eff_count(feats_r, MAX_FEATURES);
        for (int j = 0; j < nf; j++) begin
            if (train_r) begin
                sum = 0;
                for (int i = 0; i < nr; i++) sum += samples[i][j];
                mean = floor_div(sum, nr);
                sq = 0;
                for (int i = 0; i < nr; i++) begin
                    d = samples[i][j] - mean;
                    sq += d * d;
                end
                var_q = sq / nr;
                if (var_q > 64'hFFFFFFFF) var_q = 64'hFFFFFFFF;
                rm = avg_m[j] * mom_r + mean * (65536 - mom_r) + 32768;
                rv = (run_var[j] * mom_r + var_q * (65536 - mom_r) + 32768) >>> 16;
                avg_m[j] = int'(floor_div(rm, 65536));
                run_var[j] = (rv > 64'hFFFFFFFF) ? 64'hFFFFFFFF : rv;
            end else begin
                mean = avg_m[j];
                var_q = run_var[j];
            end
            mean_used[j] = int'(mean);
            inv_std[j] = inv_root(var_q);
        end
        lat_rows = nr;
        lat_feats = nf;
        stats_ok = 1'b1;
    endtask

    task automatic bn_apply(logic [1:0] f, int r, int c, logic signed [15:0] v,
                            logic signed [15:0] s);
        t_bn_result res;
        longint d;
        longint p;
        longint y;
        case (f)
            FN_PARAM: begin
                gamma_m[c] = v;
                beta_m[c] = s;
            end
            FN_SAMPLE: begin
                samples[r][c] = v;
                loaded[r][c] = 1'b1;
            end
            FN_STATS: begin
                bn_stats();
                stats_pending = 1'b1;
                n_stats++;
            end
            default: begin
                res.row = 5'(r);
                res.feat = 6'(c);
                res.norm = 0;
                res.status = 1'b1;
                if (stats_ok && r < lat_rows && c < lat_feats) begin
                    d = samples[r][c] - mean_used[c];
                    p = d * inv_std[c] * gamma_m[c];
                    y = ((p + (64'sd1 <<< 23)) >>> 24) + beta_m[c];
                    if (y > 32767) y = 32767;
                    if (y < -32768) y = -32768;
                    res.norm = y[15:0];
                    res.status = 1'b0;
                end
                expected_norm_q.push_back(res);
            end
        endcase
    endtask

    // one transaction on the input channel; valid stays high for back to back items
    task automatic send(logic [1:0] f, int r, int c, logic signed [15:0] v,
                        logic signed [15:0] s);
        int gap;
        gap = in_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        row <= 5'(r);
        feat <= 6'(c);
        value <= v;
        shift_value <= s;
        do @(posedge clk); while (in_stall);
        bn_apply(f, r, c, v, s);
        n_items++;
    endtask

    function automatic int stats_wait();
        int nr;
        int nf;
        nr = eff_count(rows_r, MAX_ROWS);
        nf = eff_count(feats_r, MAX_FEATURES);
        return nf * (train_r ? (2 * nr + 260) : 120) + 200;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_norm_q.size() != 0) @(posedge clk);
        if (stats_pending) repeat (stats_wait()) @(posedge clk);
        stats_pending = 1'b0;
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TRAIN: train_r = (data & 1) != 0;
            CFG_ROWS:  rows_r = data & 'h3F;
            CFG_FEATS: feats_r = data & 'h7F;
            CFG_MOM:   mom_r = data & 'hFFFF;
            CFG_EPS:   eps_r = data & 'hFFFF;
            default: ;
        endcase
    endtask

    task automatic configure(bit t, int nr, int nf, int m, int e);
        drain();
        cfg_write(CFG_TRAIN, t);
        cfg_write(CFG_ROWS, nr);
        cfg_write(CFG_FEATS, nf);
        cfg_write(CFG_MOM, m);
        cfg_write(CFG_EPS, e);
    endtask

    // every sample the statistics step will touch gets loaded first
    task automatic fill_batch();
        int nr;
        int nf;
        nr = eff_count(rows_r, MAX_ROWS);
        nf = eff_count(feats_r, MAX_FEATURES);
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nf; j++)
                if (!loaded[i][j]) send(FN_SAMPLE, i, j, 16'($urandom), 16'($urandom));
    endtask

    task automatic stats();
        fill_batch();
        send(FN_STATS, $urandom_range(0, 31), $urandom_range(0, 63),
             16'($urandom), 16'($urandom));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (expected_norm_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transaction row %0d feature %0d",
                                           out_row, out_feat);
            end else begin
                t_bn_result e;
                e = expected_norm_q.pop_front();
                if (e.norm !== normalized || e.row !== out_row ||
                    e.feat !== out_feat || e.status !== status) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d r%0d f%0d s%0d got %0d r%0d f%0d s%0d",
                                 e.norm, e.row, e.feat, e.status,
                                 normalized, out_row, out_feat, status);
                end
            end
            hold = out_idle ? $urandom_range(0, 16) : 0;
        end else if (hold > 0) begin
            hold--;
        end
        out_stall <= (hold != 0);
    end

    task automatic test_read_before_stats();
        send(FN_READ, 0, 0, 0, 0);
        send(FN_READ, 31, 63, 16'sh7FFF, 16'sh7FFF);
    endtask

    task automatic test_directed();
        configure(1'b1, 4, 3, 32768, 0);
        send(FN_PARAM, 0, 0, 16'sh7FFF, 16'sh7FFF);
        send(FN_PARAM, 0, 1, 16'sh8000, 16'sh8000);
        send(FN_PARAM, 0, 2, 16'sh0100, 16'sh0000);
        // feature 2 constant: zero variance with zero epsilon
        for (int i = 0; i < 4; i++) begin
            send(FN_SAMPLE, i, 0, (i[0] ? 16'sh7FFF : 16'sh8000), 0);
            send(FN_SAMPLE, i, 1, 16'(i * 300 - 400), 0);
            send(FN_SAMPLE, i, 2, 16'sh0123, 0);
        end
        stats();
        send(FN_READ, 0, 0, 0, 0);
        send(FN_READ, 1, 1, 0, 0);
        send(FN_READ, 2, 2, 0, 0);
        send(FN_READ, 4, 0, 0, 0);
        send(FN_READ, 0, 3, 0, 0);
        // data changed after statistics
        send(FN_SAMPLE, 3, 1, 16'sh7FFF, 0);
        send(FN_PARAM, 0, 1, 16'sh0200, 16'sh0080);
        send(FN_READ, 3, 1, 0, 0);
        configure(1'b0, 0, 0, 65535, 65535);
        stats();
        send(FN_READ, 0, 0, 0, 0);
        send(FN_READ, 1, 0, 0, 0);
        configure(1'b1, 63, 1, 0, 1);
        stats();
        send(FN_READ, 31, 0, 0, 0);
        configure(1'b1, 1, 127, 65535, 0);
        stats();
        send(FN_READ, 0, 63, 0, 0);
        drain();
        cfg_write(t_cfg_idx'(5), 0);
        cfg_write(t_cfg_idx'(7), 16'hFFFF);
    endtask

    task automatic test_random_phases();
        int nr;
        int nf;
        int k;
        int r;
        int c;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin nr = $urandom_range(1, 8); nf = $urandom_range(1, 8); end
                1: begin nr = 32; nf = $urandom_range(1, 4); end
                2: begin nr = $urandom_range(1, 3); nf = 64; end
                default: begin nr = $urandom_range(0, 12); nf = $urandom_range(0, 10); end
            endcase
            configure($urandom_range(0, 3) != 0, nr, nf,
                      (ph == 5) ? 0 : (ph == 6) ? 65535 : $urandom_range(0, 65535),
                      (ph == 3) ? 0 : $urandom_range(0, 65535));
            in_idle = (ph % 4) != 1;
            out_idle = (ph % 4) != 2;
            stats();
            for (int n = 0; n < 170; n++) begin
                k = $urandom_range(0, 99);
                if (k < 6) begin
                    send(FN_PARAM, $urandom_range(0, 31), $urandom_range(0, 63),
                         16'($urandom), 16'($urandom));
                end else if (k < 14) begin
                    send(FN_SAMPLE, $urandom_range(0, 31), $urandom_range(0, 63),
                         16'($urandom), 16'($urandom));
                end else if (k < 17) begin
                    stats();
                end else begin
                    if ($urandom_range(0, 9) != 0) begin
                        r = $urandom_range(0, lat_rows - 1);
                        c = $urandom_range(0, lat_feats - 1);
                    end else begin
                        r = $urandom_range(0, 31);
                        c = $urandom_range(0, 63);
                        if (r < lat_rows && c < lat_feats && !loaded[r][c]) r = lat_rows;
                        if (r > 31) r = 31;
                        if (r < lat_rows && c < lat_feats && !loaded[r][c]) c = 63;
                    end
                    send(FN_READ, r, c, 16'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_stall <= 1'b0;
        func <= FN_PARAM;
        row <= '0;
        feat <= '0;
        value <= '0;
        shift_value <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_TRAIN;
        cfg_data <= '0;
        for (int j = 0; j < MAX_FEATURES; j++) begin
            gamma_m[j] = 256;
            beta_m[j] = 0;
            avg_m[j] = 0;
            run_var[j] = 0;
        end
        train_r = 1'b0;
        rows_r = 32;
        feats_r = 64;
        mom_r = 64881;
        eps_r = 1;
        in_idle = 1'b1;
        out_idle = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_read_before_stats();
        test_directed();
        test_random_phases();
        drain();
        repeat (50) @(posedge clk);
        $display("sent %0d transactions, %0d statistics steps, checked %0d results",
                 n_items, n_stats, n_results);
        $display("mismatches: %0d, results still pending: %0d",
                 errors, expected_norm_q.size());
        if (errors == 0 && expected_norm_q.size() == 0) begin
            $display("batch_norm_layer regression: pass");
        end else begin
            $display("batch_norm_layer regression: fail");
        end
        $finish;
    end

endmodule
